@@ rtl/integer_literal_lexer_macros.svh @@
// Assertion macros used by the checker file intlit_chk.sv.
`ifndef INTEGER_LITERAL_LEXER_MACROS_SVH
`define INTEGER_LITERAL_LEXER_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define INTLIT_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds across reset.
`define INTLIT_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/intlit_pkg.sv @@
package intlit_pkg;

  // Scanner phase of the literal
  typedef enum logic [2:0] {
    PH_SIGN,
    PH_START,
    PH_ZERO,
    PH_ZRUN,
    PH_RUN,
    PH_SUFFIX,
    PH_LETTER,
    PH_DONE
  } phase_t;

  typedef enum logic [1:0] {
    RX_DEC = 2'd0,
    RX_HEX = 2'd1,
    RX_BIN = 2'd2
  } radix_t;

  typedef enum logic [2:0] {
    SUF_NONE,
    SUF_BYTE,
    SUF_SHORT,
    SUF_INT,
    SUF_LONG
  } suffix_t;

  typedef enum logic [2:0] {
    ERR_OK,
    ERR_UNDERSCORE,
    ERR_LEAD_ZERO,
    ERR_NO_DIGITS,
    ERR_NEG_UNSIGNED,
    ERR_RANGE,
    ERR_ARRAY_SUFFIX,
    ERR_TRAILING
  } err_t;

  typedef enum logic [1:0] {
    TY_BYTE,
    TY_SHORT,
    TY_INT,
    TY_LONG
  } type_t;

  typedef enum logic [1:0] {
    CTX_PLAIN,
    CTX_BYTE,
    CTX_INT,
    CTX_LONG
  } ctx_t;

  // Scanner state carried from one character to the next
  typedef struct packed {
    phase_t      phase;
    radix_t      radix;
    logic        neg;
    logic        uns;
    logic [63:0] mag;
    logic        ovf;
    logic        nonempty;
    logic        lastu;
    suffix_t     suf;
    err_t        ferr;
    logic        trl;
  } scan_t;

  // Scanner state after the last character, plus the requested context
  typedef struct packed {
    scan_t st;
    ctx_t  ctx;
  } snap_t;

  localparam scan_t SCAN_RESET = '{
    phase:    PH_SIGN,
    radix:    RX_DEC,
    neg:      1'b0,
    uns:      1'b0,
    mag:      64'd0,
    ovf:      1'b0,
    nonempty: 1'b0,
    lastu:    1'b0,
    suf:      SUF_NONE,
    ferr:     ERR_OK,
    trl:      1'b0
  };

  // Largest magnitude m with m*10 + d <= 2^63-1 for d <= 7
  localparam logic [63:0] DEC_LIMIT = 64'd922337203685477580;

  // ASCII codes
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_ONE    = 8'h31;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_LA     = 8'h61;
  localparam logic [7:0] CH_LF     = 8'h66;
  localparam logic [7:0] CH_UA     = 8'h41;
  localparam logic [7:0] CH_UF     = 8'h46;
  localparam logic [7:0] CH_MINUS  = 8'h2d;
  localparam logic [7:0] CH_PLUS   = 8'h2b;
  localparam logic [7:0] CH_USCORE = 8'h5f;
  localparam logic [7:0] CH_LX     = 8'h78;
  localparam logic [7:0] CH_UX     = 8'h58;
  localparam logic [7:0] CH_LB     = 8'h62;
  localparam logic [7:0] CH_UB     = 8'h42;
  localparam logic [7:0] CH_LS     = 8'h73;
  localparam logic [7:0] CH_US     = 8'h53;
  localparam logic [7:0] CH_LI     = 8'h69;
  localparam logic [7:0] CH_UI     = 8'h49;
  localparam logic [7:0] CH_LL     = 8'h6c;
  localparam logic [7:0] CH_UL     = 8'h4c;
  localparam logic [7:0] CH_LU     = 8'h75;
  localparam logic [7:0] CH_UU     = 8'h55;

  function automatic suffix_t letter_kind(input logic [7:0] c);
    suffix_t k;
    if (c == CH_LB || c == CH_UB) k = SUF_BYTE;
    else if (c == CH_LS || c == CH_US) k = SUF_SHORT;
    else if (c == CH_LI || c == CH_UI) k = SUF_INT;
    else if (c == CH_LL || c == CH_UL) k = SUF_LONG;
    else k = SUF_NONE;
    return k;
  endfunction

  // Largest positive value of a signed type
  function automatic logic [63:0] pos_limit(input type_t t);
    logic [63:0] r;
    case (t)
      TY_BYTE:  r = 64'd127;
      TY_SHORT: r = 64'd32767;
      TY_INT:   r = 64'd2147483647;
      default:  r = 64'h7fff_ffff_ffff_ffff;
    endcase
    return r;
  endfunction

  // Largest value of an unsigned type (long stays at 2^63-1)
  function automatic logic [63:0] uns_limit(input type_t t);
    logic [63:0] r;
    case (t)
      TY_BYTE:  r = 64'd255;
      TY_SHORT: r = 64'd65535;
      TY_INT:   r = 64'd4294967295;
      default:  r = 64'h7fff_ffff_ffff_ffff;
    endcase
    return r;
  endfunction

endpackage

@@ rtl/intlit_scan.sv @@
module intlit_scan
  import intlit_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] char_code,
  input  logic       last_char,
  input  logic [1:0] context_req,
  output logic       snap_valid,
  output snap_t      snap,
  input  logic       snap_ready
);

  scan_t scan;
  scan_t scan_next;

  logic        take;
  logic        is_dec;
  logic        is_lo;
  logic        is_up;
  logic        is_us;
  logic [3:0]  dig;
  logic        dig_ok;
  logic [63:0] accum;
  logic        over;
  logic        done;
  logic        do_run;

  assign in_ready = !snap_valid || snap_ready;
  assign take     = in_valid && in_ready;

  // Character classes and digit value under the current radix
  always_comb begin
    is_dec = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
    is_lo  = (char_code >= CH_LA) && (char_code <= CH_LF);
    is_up  = (char_code >= CH_UA) && (char_code <= CH_UF);
    is_us  = (char_code == CH_USCORE);
    if (is_dec) dig = 4'(char_code - CH_ZERO);
    else if (is_lo) dig = 4'(char_code - CH_LA + 8'd10);
    else dig = 4'(char_code - CH_UA + 8'd10);
    case (scan.radix)
      RX_HEX:  dig_ok = is_dec || is_lo || is_up;
      RX_BIN:  dig_ok = (char_code == CH_ZERO) || (char_code == CH_ONE);
      default: dig_ok = is_dec;
    endcase
  end

  // Accumulator step: shifts and adds, overflow against 2^63-1
  always_comb begin
    case (scan.radix)
      RX_HEX: begin
        accum = {scan.mag[59:0], dig};
        over  = |scan.mag[63:59];
      end
      RX_BIN: begin
        accum = {scan.mag[62:0], dig[0]};
        over  = |scan.mag[63:62];
      end
      default: begin
        accum = {scan.mag[60:0], 3'b000} + {scan.mag[62:0], 1'b0} + {60'd0, dig};
        over  = (scan.mag > DEC_LIMIT) || ((scan.mag == DEC_LIMIT) && (dig > 4'd7));
      end
    endcase
  end

  // One character through the phase chain
  always_comb begin
    scan_next = scan;
    done      = 1'b0;
    do_run    = 1'b0;
    if (scan.ferr == ERR_OK) begin
      if (scan_next.phase == PH_SIGN) begin
        scan_next.phase = PH_START;
        if (char_code == CH_MINUS) begin
          scan_next.neg = 1'b1;
          done          = 1'b1;
        end else if (char_code == CH_PLUS) begin
          done = 1'b1;
        end
      end
      if (!done && scan_next.phase == PH_START) begin
        if (char_code == CH_ZERO) begin
          scan_next.phase = PH_ZERO;
          done            = 1'b1;
        end else begin
          scan_next.phase = PH_RUN;
          scan_next.radix = RX_DEC;
        end
      end
      if (!done && scan_next.phase == PH_ZERO) begin
        if (char_code == CH_LX || char_code == CH_UX) begin
          scan_next.radix = RX_HEX;
          scan_next.phase = PH_RUN;
          done            = 1'b1;
        end else if (char_code == CH_LB || char_code == CH_UB) begin
          scan_next.radix = RX_BIN;
          scan_next.phase = PH_RUN;
          done            = 1'b1;
        end else if (is_us || is_dec) begin
          scan_next.phase = PH_ZRUN;
        end else begin
          scan_next.phase = PH_SUFFIX;
        end
      end
      // digits after a leading zero always end in an error
      if (!done && scan_next.phase == PH_ZRUN) begin
        done = 1'b1;
        if (is_us || is_dec) do_run = 1'b1;
        else scan_next.ferr = scan.lastu ? ERR_UNDERSCORE : ERR_LEAD_ZERO;
      end
      if (!done && scan_next.phase == PH_RUN) begin
        if (is_us || dig_ok) begin
          do_run = 1'b1;
          done   = 1'b1;
        end else if (!scan.nonempty) begin
          scan_next.ferr = ERR_NO_DIGITS;
          done           = 1'b1;
        end else if (scan.lastu) begin
          scan_next.ferr = ERR_UNDERSCORE;
          done           = 1'b1;
        end else begin
          scan_next.phase = PH_SUFFIX;
        end
      end
      if (!done && scan_next.phase == PH_SUFFIX) begin
        done = 1'b1;
        if (char_code == CH_LU || char_code == CH_UU) begin
          scan_next.uns   = 1'b1;
          scan_next.phase = PH_LETTER;
        end else if (char_code == CH_LS || char_code == CH_US) begin
          scan_next.phase = PH_LETTER;
        end else begin
          scan_next.suf   = letter_kind(char_code);
          scan_next.trl   = (letter_kind(char_code) == SUF_NONE) || scan.trl;
          scan_next.phase = PH_DONE;
        end
      end
      if (!done && scan_next.phase == PH_LETTER) begin
        done            = 1'b1;
        scan_next.phase = PH_DONE;
        if (letter_kind(char_code) == SUF_NONE) begin
          scan_next.suf = scan.uns ? SUF_NONE : SUF_SHORT;
          scan_next.trl = 1'b1;
        end else begin
          scan_next.suf = letter_kind(char_code);
        end
      end
      if (!done && scan_next.phase == PH_DONE) begin
        scan_next.trl = 1'b1;
      end
      // one character of a digit run
      if (do_run) begin
        if (is_us) begin
          if (!scan.nonempty || scan.lastu) begin
            scan_next.ferr = ERR_UNDERSCORE;
          end else begin
            scan_next.nonempty = 1'b1;
            scan_next.lastu    = 1'b1;
          end
        end else begin
          scan_next.nonempty = 1'b1;
          scan_next.lastu    = 1'b0;
          if (!scan.ovf) begin
            if (over) scan_next.ovf = 1'b1;
            else scan_next.mag = accum;
          end
        end
      end
    end
  end

  // State update; the last character hands the state over and clears it
  always_ff @(posedge clk) begin
    if (rst) begin
      scan       <= SCAN_RESET;
      snap_valid <= 1'b0;
    end else begin
      if (take && last_char) begin
        snap_valid <= 1'b1;
      end else if (snap_ready) begin
        snap_valid <= 1'b0;
      end
      if (take) begin
        if (last_char) begin
          scan <= SCAN_RESET;
        end else begin
          scan <= scan_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && last_char) begin
      snap.st  <= scan_next;
      snap.ctx <= ctx_t'(context_req);
    end
  end

endmodule

@@ rtl/intlit_eval.sv @@
module intlit_eval
  import intlit_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        snap_valid,
  input  snap_t       snap,
  output logic        snap_ready,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] value,
  output logic [1:0]  type_code,
  output logic [2:0]  error_code
);

  err_t        ferr;
  suffix_t     suf;
  type_t       ty;
  err_t        err;
  logic [63:0] mag;
  logic [63:0] val;
  logic [63:0] uns_val;
  logic        bad_suffix;

  assign snap_ready = !out_valid || out_ready;
  assign mag        = snap.st.mag;

  // End-of-literal checks left open by the phase
  always_comb begin
    ferr = snap.st.ferr;
    suf  = snap.st.suf;
    if (ferr == ERR_OK) begin
      case (snap.st.phase)
        PH_SIGN, PH_START: ferr = ERR_NO_DIGITS;
        PH_ZRUN: ferr = snap.st.lastu ? ERR_UNDERSCORE : ERR_LEAD_ZERO;
        PH_RUN: begin
          if (!snap.st.nonempty) ferr = ERR_NO_DIGITS;
          else if (snap.st.lastu) ferr = ERR_UNDERSCORE;
        end
        PH_LETTER: if (!snap.st.uns) suf = SUF_SHORT;
        default: ;
      endcase
    end
  end

  // Target type: the suffix, else the default of the context
  always_comb begin
    case (suf)
      SUF_BYTE:  ty = TY_BYTE;
      SUF_SHORT: ty = TY_SHORT;
      SUF_INT:   ty = TY_INT;
      SUF_LONG:  ty = TY_LONG;
      default: begin
        case (snap.ctx)
          CTX_BYTE: ty = TY_BYTE;
          CTX_LONG: ty = TY_LONG;
          default:  ty = TY_INT;
        endcase
      end
    endcase
  end

  // Unsigned values keep the bit pattern of their width
  always_comb begin
    case (ty)
      TY_BYTE:  uns_val = {{56{mag[7]}}, mag[7:0]};
      TY_SHORT: uns_val = {{48{mag[15]}}, mag[15:0]};
      TY_INT:   uns_val = {{32{mag[31]}}, mag[31:0]};
      default:  uns_val = mag;
    endcase
  end

  // Error precedence and range check
  always_comb begin
    bad_suffix = (suf != SUF_NONE) &&
                 (((snap.ctx == CTX_BYTE) && (suf != SUF_BYTE)) ||
                  ((snap.ctx == CTX_INT) && (suf == SUF_LONG)));
    err = ERR_OK;
    val = 64'd0;
    if (ferr != ERR_OK) begin
      err = ferr;
    end else if (bad_suffix) begin
      err = ERR_ARRAY_SUFFIX;
    end else if (snap.st.uns && snap.st.neg) begin
      err = ERR_NEG_UNSIGNED;
    end else if (snap.st.ovf) begin
      err = ERR_RANGE;
    end else if (snap.st.uns) begin
      if (mag > uns_limit(ty)) err = ERR_RANGE;
      else val = uns_val;
    end else if (snap.st.neg) begin
      if (mag > pos_limit(ty) + 64'd1) err = ERR_RANGE;
      else val = 64'd0 - mag;
    end else begin
      if (mag > pos_limit(ty)) err = ERR_RANGE;
      else val = mag;
    end
    if (err == ERR_OK && snap.st.trl) err = ERR_TRAILING;
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (snap_ready) begin
      out_valid <= snap_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (snap_ready && snap_valid) begin
      if (err == ERR_OK) begin
        value     <= val;
        type_code <= ty;
      end else begin
        value     <= 64'd0;
        type_code <= TY_BYTE;
      end
      error_code <= err;
    end
  end

endmodule

@@ rtl/integer_literal_lexer.sv @@
// Integer literal lexer: takes one character of a literal per cycle (optional
// sign, 0x / 0b / decimal digits with single underscores, optional b s i l u
// suffix) and, on the character marked last_char, returns one item with the
// sign-extended value, its type and an error code; other characters return
// nothing. A new character is taken every cycle while out_ready is high. The
// last character's scanner state is registered in the character scanner,
// whose longest path is the decimal accumulator (mag*10 + digit as shifts
// and two adds), and then in the result register after the range check and
// negation. context_req counts only on the last character.
module integer_literal_lexer
  import intlit_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  char_code,
  input  logic        last_char,
  input  logic [1:0]  context_req,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] value,
  output logic [1:0]  type_code,
  output logic [2:0]  error_code
);

  logic  snap_valid;
  logic  snap_ready;
  snap_t snap;

  // Character scanner
  intlit_scan u_scan (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .char_code   (char_code),
    .last_char   (last_char),
    .context_req (context_req),
    .snap_valid  (snap_valid),
    .snap        (snap),
    .snap_ready  (snap_ready)
  );

  // Range check and result register
  intlit_eval u_eval (
    .clk        (clk),
    .rst        (rst),
    .snap_valid (snap_valid),
    .snap       (snap),
    .snap_ready (snap_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .value      (value),
    .type_code  (type_code),
    .error_code (error_code)
  );

endmodule

@@ rtl/intlit_chk.sv @@
`include "integer_literal_lexer_macros.svh"

module intlit_chk
  import intlit_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] value,
  input logic [1:0]  type_code,
  input logic [2:0]  error_code
);

  // no result straight out of reset
  `INTLIT_ASSERT_ALWAYS(a_reset_idle, rst |=> !out_valid, "result valid after reset")

  // a stalled result holds
  `INTLIT_ASSERT(a_hold, out_valid && !out_ready |=> out_valid && $stable(value) && $stable(type_code) && $stable(error_code), "stalled result changed")

  // error results carry zero value and type
  `INTLIT_ASSERT(a_err_zero, out_valid && error_code != ERR_OK |-> value == 64'd0 && type_code == TY_BYTE, "error result not cleared")

  // good byte results are sign-extended from 8 bits
  `INTLIT_ASSERT(a_byte_ext, out_valid && error_code == ERR_OK && type_code == TY_BYTE |-> value[63:7] == '0 || value[63:7] == '1, "byte value not sign-extended")

  // good int results are sign-extended from 32 bits
  `INTLIT_ASSERT(a_int_ext, out_valid && error_code == ERR_OK && type_code == TY_INT |-> value[63:31] == '0 || value[63:31] == '1, "int value not sign-extended")

endmodule

bind integer_literal_lexer intlit_chk u_chk (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .value      (value),
  .type_code  (type_code),
  .error_code (error_code)
);
